// File: rtl/aesp_pkg.sv
// ----------------------------------------------------------------------------
// aesp_pkg: shared types and constants for the escape sequence parser
// Character codes, result kinds, parser modes and the packed result layout.
// ----------------------------------------------------------------------------
package aesp_pkg;

	localparam int MAX_PARAMS_DEF = 8;
	localparam int TEXT_DEPTH_DEF = 64;

	localparam int CHAR_W  = 21;
	localparam int PARAM_W = 14;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 112;

	// character codes
	localparam logic [CHAR_W-1:0] CH_BEL   = 21'd7;
	localparam logic [CHAR_W-1:0] CH_ESC   = 21'd27;
	localparam logic [CHAR_W-1:0] CH_SPACE = 21'd32;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 21'd48;
	localparam logic [CHAR_W-1:0] CH_NINE  = 21'd57;
	localparam logic [CHAR_W-1:0] CH_SEMI  = 21'd59;
	localparam logic [CHAR_W-1:0] CH_LBRK  = 21'd91;
	localparam logic [CHAR_W-1:0] CH_RBRK  = 21'd93;
	localparam logic [CHAR_W-1:0] CH_UP    = 21'd65;
	localparam logic [CHAR_W-1:0] CH_DOWN  = 21'd66;
	localparam logic [CHAR_W-1:0] CH_FWD   = 21'd67;
	localparam logic [CHAR_W-1:0] CH_BACK  = 21'd68;
	localparam logic [CHAR_W-1:0] CH_POS_H = 21'd72;
	localparam logic [CHAR_W-1:0] CH_ED    = 21'd74;
	localparam logic [CHAR_W-1:0] CH_EL    = 21'd75;
	localparam logic [CHAR_W-1:0] CH_POS_F = 21'd102;
	localparam logic [CHAR_W-1:0] CH_SGR   = 21'd109;
	localparam logic [CHAR_W-1:0] CH_WIN   = 21'd116;

	localparam logic [PARAM_W-1:0] PARAM_CAP = 14'd1000;
	localparam logic [PARAM_W-1:0] WIN_MAX   = 14'd4095;
	localparam logic [PARAM_W-1:0] FG_LO     = 14'd30;
	localparam logic [PARAM_W-1:0] FG_HI     = 14'd37;
	localparam logic [PARAM_W-1:0] BG_LO     = 14'd40;
	localparam logic [PARAM_W-1:0] BG_HI     = 14'd47;
	localparam logic [3:0]         COLOR_DEF = 4'd8;

	typedef enum logic [3:0] {
		OP_PLAIN       = 4'd0,
		OP_CONTROL     = 4'd1,
		OP_NOOP        = 4'd2,
		OP_MOVE_ROW    = 4'd3,
		OP_MOVE_COL    = 4'd4,
		OP_MOVE_ABS    = 4'd5,
		OP_ERASE_DISP  = 4'd6,
		OP_ERASE_LINE  = 4'd7,
		OP_SET_ATTRS   = 4'd8,
		OP_WINDOW_OP   = 4'd9,
		OP_WINDOW_TEXT = 4'd10
	} op_kind_t;

	typedef enum logic [1:0] {
		MODE_TEXT  = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_PARAM = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROC,
		S_RD,
		S_USE,
		S_EMIT,
		S_TRD,
		S_TOUT
	} state_t;

	// result word, lowest field in the lowest bits
	typedef struct packed {
		logic               pad;
		logic [31:0]        window_arg;
		logic [3:0]         bg_color;
		logic [3:0]         fg_color;
		logic [2:0]         style_bits;
		logic [13:0]        abs_col;
		logic [13:0]        abs_row;
		logic signed [14:0] amount;
		logic [CHAR_W-1:0]  out_char;
		op_kind_t           op_kind;
	} result_t;

endpackage

// File: rtl/aesp_ram.sv
// ----------------------------------------------------------------------------
// aesp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module aesp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/ansi_escape_sequence_parser.sv
// ----------------------------------------------------------------------------
// ansi_escape_sequence_parser: terminal escape sequence parser
// Follows ESC [ (CSI) and ESC ] (OSC) sequences one character at a time.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                          | other
//  --------+-----+---------------------------------------------+----------
//  s_axis  | in  | char_code[20:0], zero pad                   | -
//  m_axis  | out | op_kind, out_char, amount, abs_row, abs_col,| tlast=last
//          |     | style_bits, fg_color, bg_color, window_arg  |
//
//  An accepted character is held and worked on in the following cycles.
//  A plain character, digit or separator is handled in S_PROC. A CSI final
//  walks the parameter memory through S_RD and S_USE per parameter and then
//  emits from S_EMIT. An OSC text run emits one result per character through
//  S_TRD and S_TOUT, reading each from the single read port of the text memory.
//  The output register lets a new request enter while a result waits.
//  arst_n clears mode, indexes and attributes; the memories need no clearing.
//
module ansi_escape_sequence_parser #(
	parameter int MAX_PARAMS = aesp_pkg::MAX_PARAMS_DEF,
	parameter int TEXT_DEPTH = aesp_pkg::TEXT_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [aesp_pkg::IN_W-1:0]  s_axis_tdata,  // char_code[20:0]
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// op_kind[3:0] out_char[24:4] amount[39:25] abs_row[53:40] abs_col[67:54]
	// style_bits[70:68] fg_color[74:71] bg_color[78:75] window_arg[110:79]
	output logic [aesp_pkg::OUT_W-1:0] m_axis_tdata,
	output logic                       m_axis_tlast
);

	localparam int PAW = $clog2(MAX_PARAMS);
	localparam int TAW = $clog2(TEXT_DEPTH);
	localparam logic [PAW-1:0] IDX_LAST = PAW'(MAX_PARAMS - 1);
	localparam logic [13:0]    TXT_CAP  = 14'(TEXT_DEPTH - 1);

	aesp_pkg::state_t  state_q, state_d;
	aesp_pkg::mode_t   mode_q;
	logic              osc_q;
	logic [PAW-1:0]    idx_q, j_q;
	logic [13:0]       cur_q;       // current parameter; text count in OSC text
	logic [13:0]       osc_arg_q;
	logic [20:0]       ch_q;
	logic [13:0]       p0_q, p1_q, p2_q;
	logic [TAW-1:0]    ti_q;
	logic [2:0]        sty_q;
	logic [3:0]        fg_q, bg_q;

	aesp_pkg::result_t res, out_q;
	logic              res_last, emit, out_valid_q, out_last_q, out_free;

	logic              pv_we;
	logic [13:0]       pv_rdata;
	logic              tx_we;
	logic [20:0]       tx_rdata;

	logic              is_digit, is_semi, in_text;
	logic [13:0]       mag, x;

	aesp_ram #(.WIDTH(14), .DEPTH(MAX_PARAMS)) u_param_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (idx_q),
		.wdata (cur_q),
		.raddr (j_q),
		.rdata (pv_rdata)
	);

	aesp_ram #(.WIDTH(21), .DEPTH(TEXT_DEPTH)) u_text_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (cur_q[TAW-1:0]),
		.wdata (ch_q),
		.raddr (ti_q),
		.rdata (tx_rdata)
	);

	assign s_axis_tready = (state_q == aesp_pkg::S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tlast  = out_last_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign is_digit = (ch_q >= aesp_pkg::CH_ZERO) && (ch_q <= aesp_pkg::CH_NINE);
	assign is_semi  = (ch_q == aesp_pkg::CH_SEMI);
	assign in_text  = osc_q && (idx_q == PAW'(1));
	assign mag      = (p0_q == 14'd0) ? 14'd1 : p0_q;
	assign x        = pv_rdata;

	// next state, memory writes and the result word
	always_comb begin
		state_d  = state_q;
		pv_we    = 1'b0;
		tx_we    = 1'b0;
		emit     = 1'b0;
		res      = '0;
		res_last = 1'b1;
		unique case (state_q)
			aesp_pkg::S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = aesp_pkg::S_PROC;
				end
			end
			aesp_pkg::S_PROC: begin
				case (mode_q)
					aesp_pkg::MODE_TEXT: begin
						if (ch_q == aesp_pkg::CH_ESC) begin
							state_d = aesp_pkg::S_IDLE;
						end else begin
							res.op_kind  = (ch_q >= aesp_pkg::CH_SPACE) ?
								aesp_pkg::OP_PLAIN : aesp_pkg::OP_CONTROL;
							res.out_char = ch_q;
							if (out_free) begin
								emit    = 1'b1;
								state_d = aesp_pkg::S_IDLE;
							end
						end
					end
					aesp_pkg::MODE_ESC: begin
						state_d = aesp_pkg::S_IDLE;
					end
					default: begin
						if (in_text) begin
							if (ch_q == aesp_pkg::CH_BEL) begin
								if (cur_q == 14'd0) begin
									// empty text still gives one result
									res.op_kind    = aesp_pkg::OP_WINDOW_TEXT;
									res.window_arg = 32'(osc_arg_q);
									if (out_free) begin
										emit    = 1'b1;
										state_d = aesp_pkg::S_IDLE;
									end
								end else begin
									state_d = aesp_pkg::S_TRD;
								end
							end else begin
								tx_we   = (cur_q < TXT_CAP);
								state_d = aesp_pkg::S_IDLE;
							end
						end else if (is_digit) begin
							state_d = aesp_pkg::S_IDLE;
						end else if (is_semi) begin
							pv_we   = 1'b1;
							state_d = aesp_pkg::S_IDLE;
						end else begin
							// final: flush current parameter, then walk them
							pv_we   = 1'b1;
							state_d = aesp_pkg::S_RD;
						end
					end
				endcase
			end
			aesp_pkg::S_RD: begin
				state_d = aesp_pkg::S_USE;
			end
			aesp_pkg::S_USE: begin
				state_d = (j_q == idx_q) ? aesp_pkg::S_EMIT : aesp_pkg::S_RD;
			end
			aesp_pkg::S_EMIT: begin
				res.op_kind = aesp_pkg::OP_NOOP;
				case (ch_q) inside
					aesp_pkg::CH_UP, aesp_pkg::CH_DOWN, aesp_pkg::CH_FWD,
					aesp_pkg::CH_BACK: begin
						res.op_kind = (ch_q == aesp_pkg::CH_UP || ch_q == aesp_pkg::CH_DOWN) ?
							aesp_pkg::OP_MOVE_ROW : aesp_pkg::OP_MOVE_COL;
						res.amount  = (ch_q == aesp_pkg::CH_UP || ch_q == aesp_pkg::CH_BACK) ?
							-$signed({1'b0, mag}) : $signed({1'b0, mag});
					end
					aesp_pkg::CH_POS_H, aesp_pkg::CH_POS_F: begin
						res.op_kind = aesp_pkg::OP_MOVE_ABS;
						res.abs_row = mag - 14'd1;
						res.abs_col = (idx_q == '0 || p1_q == 14'd0) ? 14'd0 :
							p1_q - 14'd1;
					end
					aesp_pkg::CH_ED, aesp_pkg::CH_EL: begin
						res.op_kind = (ch_q == aesp_pkg::CH_ED) ?
							aesp_pkg::OP_ERASE_DISP : aesp_pkg::OP_ERASE_LINE;
						res.amount  = $signed({1'b0, p0_q});
					end
					aesp_pkg::CH_SGR: begin
						res.op_kind    = aesp_pkg::OP_SET_ATTRS;
						res.style_bits = sty_q;
						res.fg_color   = fg_q;
						res.bg_color   = bg_q;
					end
					aesp_pkg::CH_WIN: begin
						if (p0_q == 14'd3 || p0_q == 14'd4 || p0_q == 14'd8) begin
							if (idx_q == PAW'(2) && p1_q <= aesp_pkg::WIN_MAX &&
									p2_q <= aesp_pkg::WIN_MAX) begin
								res.op_kind    = aesp_pkg::OP_WINDOW_OP;
								res.window_arg = {p2_q[11:0], p1_q[11:0], p0_q[7:0]};
							end
						end else if (p0_q == 14'd9) begin
							if (idx_q == PAW'(1) && p1_q <= aesp_pkg::WIN_MAX) begin
								res.op_kind    = aesp_pkg::OP_WINDOW_OP;
								res.window_arg = {12'd0, p1_q[11:0], p0_q[7:0]};
							end
						end else if (idx_q == '0 && p0_q >= 14'd1 && p0_q <= 14'd9) begin
							res.op_kind    = aesp_pkg::OP_WINDOW_OP;
							res.window_arg = 32'(p0_q);
						end
					end
					default: begin
						res.op_kind = aesp_pkg::OP_NOOP;
					end
				endcase
				if (out_free) begin
					emit    = 1'b1;
					state_d = aesp_pkg::S_IDLE;
				end
			end
			aesp_pkg::S_TRD: begin
				state_d = aesp_pkg::S_TOUT;
			end
			aesp_pkg::S_TOUT: begin
				res.op_kind    = aesp_pkg::OP_WINDOW_TEXT;
				res.out_char   = tx_rdata;
				res.window_arg = 32'(osc_arg_q);
				res_last       = (14'(ti_q) + 14'd1 == cur_q);
				if (out_free) begin
					emit    = 1'b1;
					state_d = res_last ? aesp_pkg::S_IDLE : aesp_pkg::S_TRD;
				end
			end
			default: begin
				state_d = aesp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aesp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register: hold until taken, refill when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q      <= res;
			out_last_q <= res_last;
		end
	end

	// parser control state and attributes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= aesp_pkg::MODE_TEXT;
			osc_q  <= 1'b0;
			idx_q  <= '0;
			sty_q  <= 3'd0;
			fg_q   <= aesp_pkg::COLOR_DEF;
			bg_q   <= aesp_pkg::COLOR_DEF;
			j_q    <= '0;
			ti_q   <= '0;
		end else begin
			if (state_q == aesp_pkg::S_PROC && state_d != aesp_pkg::S_PROC) begin
				case (mode_q)
					aesp_pkg::MODE_TEXT: begin
						if (ch_q == aesp_pkg::CH_ESC) begin
							mode_q <= aesp_pkg::MODE_ESC;
						end
					end
					aesp_pkg::MODE_ESC: begin
						if (ch_q == aesp_pkg::CH_LBRK || ch_q == aesp_pkg::CH_RBRK) begin
							osc_q  <= (ch_q == aesp_pkg::CH_RBRK);
							idx_q  <= '0;
							mode_q <= aesp_pkg::MODE_PARAM;
						end else begin
							mode_q <= aesp_pkg::MODE_TEXT;
						end
					end
					default: begin
						if (in_text) begin
							if (ch_q == aesp_pkg::CH_BEL) begin
								mode_q <= aesp_pkg::MODE_TEXT;
								ti_q   <= '0;
							end
						end else if (is_digit) begin
							// digits do not touch control state
						end else if (is_semi) begin
							if (idx_q != IDX_LAST) begin
								idx_q <= idx_q + PAW'(1);
							end
						end else begin
							mode_q <= aesp_pkg::MODE_TEXT;
							j_q    <= '0;
						end
					end
				endcase
			end
			// apply SGR codes while walking the parameters
			if (state_q == aesp_pkg::S_USE) begin
				j_q <= j_q + PAW'(1);
				if (ch_q == aesp_pkg::CH_SGR) begin
					if (x == 14'd0) begin
						sty_q <= 3'd0;
						fg_q  <= aesp_pkg::COLOR_DEF;
						bg_q  <= aesp_pkg::COLOR_DEF;
					end else if (x == 14'd1) begin
						sty_q[0] <= 1'b1;
					end else if (x == 14'd4) begin
						sty_q[1] <= 1'b1;
					end else if (x == 14'd7) begin
						sty_q[2] <= 1'b1;
					end else if (x >= aesp_pkg::FG_LO && x <= aesp_pkg::FG_HI) begin
						fg_q <= 4'(x - aesp_pkg::FG_LO);
					end else if (x >= aesp_pkg::BG_LO && x <= aesp_pkg::BG_HI) begin
						bg_q <= 4'(x - aesp_pkg::BG_LO);
					end
				end
			end
			if (state_q == aesp_pkg::S_TOUT && emit) begin
				ti_q <= ti_q + TAW'(1);
			end
		end
	end

	// payload: held character, current parameter, captured parameters
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_q <= s_axis_tdata[20:0];
		end
		if (state_q == aesp_pkg::S_PROC && state_d != aesp_pkg::S_PROC) begin
			case (mode_q)
				aesp_pkg::MODE_TEXT: begin
				end
				aesp_pkg::MODE_ESC: begin
					cur_q <= 14'd0;
				end
				default: begin
					if (in_text) begin
						if (ch_q != aesp_pkg::CH_BEL && cur_q < TXT_CAP) begin
							cur_q <= cur_q + 14'd1;
						end
					end else if (is_digit) begin
						if (cur_q < aesp_pkg::PARAM_CAP) begin
							cur_q <= (cur_q << 3) + (cur_q << 1) + 14'(ch_q - aesp_pkg::CH_ZERO);
						end
					end else if (is_semi) begin
						if (osc_q && idx_q == '0) begin
							osc_arg_q <= cur_q;
						end
						cur_q <= 14'd0;
					end else begin
						p1_q <= 14'd0;
						p2_q <= 14'd0;
					end
				end
			endcase
		end
		if (state_q == aesp_pkg::S_USE) begin
			if (j_q == PAW'(0)) begin
				p0_q <= x;
			end
			if (j_q == PAW'(1)) begin
				p1_q <= x;
			end
			if (j_q == PAW'(2)) begin
				p2_q <= x;
			end
		end
	end

endmodule

// File: rtl/aesp_chk.sv
// ----------------------------------------------------------------------------
// aesp_chk: port checker for the escape sequence parser
// Watches the stream ports and flags protocol and result slips.
// ----------------------------------------------------------------------------
module aesp_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [aesp_pkg::OUT_W-1:0] m_axis_tdata,
	input logic                       m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while previous one in work");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:0] <= aesp_pkg::OP_WINDOW_TEXT)
		else $error("result kind out of range");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3:0] != aesp_pkg::OP_WINDOW_TEXT |-> m_axis_tlast)
		else $error("single result without last");

endmodule

bind ansi_escape_sequence_parser aesp_chk u_aesp_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for ansi_escape_sequence_parser
// Streams directed and random character runs (plain, control, CSI and OSC
// sequences, broken sequences) into the parser, predicts every result
// in a scoreboard and compares the result stream field by field.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int LONG_HOLD      = 300;
	localparam int TOTAL_CHARS    = 230;

	typedef struct {
		aesp_pkg::result_t r;
		logic              last;
	} expected_t;

	// Parser behavior model plus the queue of results still owed by the block.
	class ansi_result_predictor;
		aesp_pkg::mode_t  mode;
		int unsigned      pidx;
		bit               osc;
		logic [13:0]      prm[aesp_pkg::MAX_PARAMS_DEF];
		logic [20:0]      text[aesp_pkg::TEXT_DEPTH_DEF];
		logic [2:0]       style;
		logic [3:0]       fg;
		logic [3:0]       bg;
		expected_t        owed[$];
		int               errors;

		function new();
			mode = aesp_pkg::MODE_TEXT;
			pidx = 0;
			osc = 0;
			style = '0;
			fg = aesp_pkg::COLOR_DEF;
			bg = aesp_pkg::COLOR_DEF;
			errors = 0;
			foreach (prm[i]) prm[i] = '0;
			foreach (text[i]) text[i] = '0;
		endfunction

		function void push(aesp_pkg::op_kind_t k, logic [20:0] ch, int amt, int row,
				int col, logic [2:0] sty, logic [3:0] f, logic [3:0] b,
				logic [31:0] warg);
			expected_t e;
			e.r = '0;
			e.r.op_kind = k;
			e.r.out_char = ch;
			e.r.amount = amt[14:0];
			e.r.abs_row = row[13:0];
			e.r.abs_col = col[13:0];
			e.r.style_bits = sty;
			e.r.fg_color = f;
			e.r.bg_color = b;
			e.r.window_arg = warg;
			e.last = 1'b0;
			owed.push_back(e);
		endfunction

		// close a CSI (or OSC-before-separator) sequence on its final character
		function void finish_seq(logic [20:0] c);
			int p0, p1, p2, a, x;
			bit ok;
			logic [31:0] arg;
			p0 = prm[0];
			p1 = prm[1];
			p2 = prm[2];
			mode = aesp_pkg::MODE_TEXT;
			if (c == aesp_pkg::CH_UP || c == aesp_pkg::CH_DOWN ||
					c == aesp_pkg::CH_FWD || c == aesp_pkg::CH_BACK) begin
				a = (p0 == 0) ? 1 : p0;
				if (c == aesp_pkg::CH_UP || c == aesp_pkg::CH_BACK)
					a = -a;
				push((c == aesp_pkg::CH_UP || c == aesp_pkg::CH_DOWN) ?
					aesp_pkg::OP_MOVE_ROW : aesp_pkg::OP_MOVE_COL,
					'0, a, 0, 0, '0, '0, '0, '0);
			end else if (c == aesp_pkg::CH_POS_H || c == aesp_pkg::CH_POS_F) begin
				push(aesp_pkg::OP_MOVE_ABS, '0, 0, ((p0 == 0) ? 1 : p0) - 1,
					((pidx < 1 || p1 == 0) ? 1 : p1) - 1, '0, '0, '0, '0);
			end else if (c == aesp_pkg::CH_ED || c == aesp_pkg::CH_EL) begin
				push((c == aesp_pkg::CH_ED) ? aesp_pkg::OP_ERASE_DISP :
					aesp_pkg::OP_ERASE_LINE, '0, p0, 0, 0, '0, '0, '0, '0);
			end else if (c == aesp_pkg::CH_SGR) begin
				for (int j = 0; j <= pidx && j < aesp_pkg::MAX_PARAMS_DEF; j++) begin
					x = prm[j];
					if (x == 0) begin
						style = '0;
						fg = aesp_pkg::COLOR_DEF;
						bg = aesp_pkg::COLOR_DEF;
					end else if (x == 1) style[0] = 1'b1;
					else if (x == 4) style[1] = 1'b1;
					else if (x == 7) style[2] = 1'b1;
					else if (x >= aesp_pkg::FG_LO && x <= aesp_pkg::FG_HI)
						fg = 4'(x - aesp_pkg::FG_LO);
					else if (x >= aesp_pkg::BG_LO && x <= aesp_pkg::BG_HI)
						bg = 4'(x - aesp_pkg::BG_LO);
				end
				push(aesp_pkg::OP_SET_ATTRS, '0, 0, 0, 0, style, fg, bg, '0);
			end else if (c == aesp_pkg::CH_WIN) begin
				ok = 0;
				arg = '0;
				if (p0 == 3 || p0 == 4 || p0 == 8) begin
					if (pidx == 2 && p1 <= aesp_pkg::WIN_MAX && p2 <= aesp_pkg::WIN_MAX) begin
						arg = (p2 << 20) + (p1 << 8) + p0;
						ok = 1;
					end
				end else if (p0 == 9) begin
					if (pidx == 1 && p1 <= aesp_pkg::WIN_MAX) begin
						arg = (p1 << 8) + p0;
						ok = 1;
					end
				end else if (pidx == 0 && p0 >= 1 && p0 <= 9) begin
					arg = p0;
					ok = 1;
				end
				push(ok ? aesp_pkg::OP_WINDOW_OP : aesp_pkg::OP_NOOP, '0, 0, 0, 0,
					'0, '0, '0, arg);
			end else begin
				push(aesp_pkg::OP_NOOP, '0, 0, 0, 0, '0, '0, '0, '0);
			end
		endfunction

		// advance the model by one accepted request
		function void note_char(logic [20:0] c);
			int before_n, cnt, p;
			before_n = owed.size();
			if (mode == aesp_pkg::MODE_TEXT) begin
				if (c >= aesp_pkg::CH_SPACE)
					push(aesp_pkg::OP_PLAIN, c, 0, 0, 0, '0, '0, '0, '0);
				else if (c != aesp_pkg::CH_ESC)
					push(aesp_pkg::OP_CONTROL, c, 0, 0, 0, '0, '0, '0, '0);
				else mode = aesp_pkg::MODE_ESC;
			end else if (mode == aesp_pkg::MODE_ESC) begin
				if (c == aesp_pkg::CH_LBRK || c == aesp_pkg::CH_RBRK) begin
					osc = (c == aesp_pkg::CH_RBRK);
					pidx = 0;
					prm[0] = '0;
					mode = aesp_pkg::MODE_PARAM;
				end else begin
					mode = aesp_pkg::MODE_TEXT;
				end
			end else begin
				if (pidx >= aesp_pkg::MAX_PARAMS_DEF) pidx = aesp_pkg::MAX_PARAMS_DEF - 1;
				if (osc && pidx == 1) begin
					cnt = prm[1];
					if (c == aesp_pkg::CH_BEL) begin
						mode = aesp_pkg::MODE_TEXT;
						if (cnt > aesp_pkg::TEXT_DEPTH_DEF - 1) cnt = aesp_pkg::TEXT_DEPTH_DEF - 1;
						if (cnt == 0)
							push(aesp_pkg::OP_WINDOW_TEXT, '0, 0, 0, 0, '0, '0, '0,
								32'(prm[0]));
						for (int i = 0; i < cnt; i++)
							push(aesp_pkg::OP_WINDOW_TEXT, text[i], 0, 0, 0, '0, '0, '0,
								32'(prm[0]));
					end else if (cnt < aesp_pkg::TEXT_DEPTH_DEF - 1) begin
						text[cnt] = c;
						prm[1] = 14'(cnt + 1);
					end
				end else if (c >= aesp_pkg::CH_ZERO && c <= aesp_pkg::CH_NINE) begin
					p = prm[pidx];
					if (p < aesp_pkg::PARAM_CAP)
						prm[pidx] = 14'(p * 10 + (c - aesp_pkg::CH_ZERO));
				end else if (c == aesp_pkg::CH_SEMI) begin
					if (pidx < aesp_pkg::MAX_PARAMS_DEF - 1) pidx++;
					prm[pidx] = '0;
				end else begin
					finish_seq(c);
				end
			end
			if (owed.size() > before_n) owed[owed.size() - 1].last = 1'b1;
		endfunction

		function void report(string field, longint exp_v, longint act_v);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
				exp_v, act_v);
		endfunction

		// compare one accepted result with the oldest owed result
		function void check_result(logic [aesp_pkg::OUT_W-1:0] data, logic last);
			aesp_pkg::result_t got;
			expected_t e;
			got = aesp_pkg::result_t'(data);
			if (owed.size() == 0) begin
				report("unexpected result op_kind", -1, got.op_kind);
				return;
			end
			e = owed.pop_front();
			if (got.op_kind !== e.r.op_kind) report("op_kind", e.r.op_kind, got.op_kind);
			if (got.out_char !== e.r.out_char) report("out_char", e.r.out_char, got.out_char);
			if (got.amount !== e.r.amount) report("amount", e.r.amount, got.amount);
			if (got.abs_row !== e.r.abs_row) report("abs_row", e.r.abs_row, got.abs_row);
			if (got.abs_col !== e.r.abs_col) report("abs_col", e.r.abs_col, got.abs_col);
			if (got.style_bits !== e.r.style_bits)
				report("style_bits", e.r.style_bits, got.style_bits);
			if (got.fg_color !== e.r.fg_color) report("fg_color", e.r.fg_color, got.fg_color);
			if (got.bg_color !== e.r.bg_color) report("bg_color", e.r.bg_color, got.bg_color);
			if (got.window_arg !== e.r.window_arg)
				report("window_arg", e.r.window_arg, got.window_arg);
			if (last !== e.last) report("tlast", e.last, last);
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [aesp_pkg::IN_W-1:0]     s_axis_tdata;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [aesp_pkg::OUT_W-1:0]    m_axis_tdata;
	logic                          m_axis_tlast;

	ansi_result_predictor predictor;
	int  idle_cycles = 0;
	int  chars_sent;
	bit  send_burst = 0;     // sender offers back to back while set
	bit  recv_burst = 0;     // receiver takes no random stalls while set
	bit  hold_request = 0;   // asks the receiver for one long hold-off

	ansi_escape_sequence_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Sample both handshakes at the rising edge: check results first, since
	// a request accepted at this edge cannot have produced them yet.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				predictor.check_result(m_axis_tdata, m_axis_tlast);
			if (s_axis_tvalid && s_axis_tready)
				predictor.note_char(s_axis_tdata[aesp_pkg::CHAR_W-1:0]);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// watchdog: nothing moved for too long
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: random stalls, bursts of none, and one long hold-off on request
	initial begin
		int stall;
		bit held;
		stall = 0;
		held = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !held) begin
				held = 1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				stall = 0;
			end
			if (!recv_burst && stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!recv_burst && $urandom_range(0, 3) == 0) stall = pick_gap();
				if ($urandom_range(0, 40) == 0) recv_burst = !recv_burst;
			end
		end
	end

	// Offer one character and hold it until accepted; called at a falling edge.
	task automatic send_char(logic [20:0] c);
		int gap;
		gap = send_burst ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, c};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		@(negedge clk);
		chars_sent++;
		if ($urandom_range(0, 30) == 0) send_burst = !send_burst;
	endtask

	task automatic send_str(string s);
		foreach (s[i]) send_char(21'(s[i]));
	endtask

	task automatic send_num(int unsigned v);
		string s;
		s.itoa(v);
		send_str(s);
	endtask

	// parameter value weighted toward meaningful codes
	function automatic int unsigned pick_param();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return $urandom_range(0, 9);
		if (r < 65) return $urandom_range(30, 47);
		if (r < 85) return $urandom_range(0, 4200);
		return $urandom_range(0, 999999);
	endfunction

	// well-formed CSI with random parameters; sometimes an odd final
	task automatic csi_seq();
		string finals;
		int n;
		finals = "ABCDHfJKmtt";
		send_char(aesp_pkg::CH_ESC);
		send_char(aesp_pkg::CH_LBRK);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 11) : $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			if (i > 0) send_char(aesp_pkg::CH_SEMI);
			if ($urandom_range(0, 5) != 0) send_num(pick_param());
		end
		if ($urandom_range(0, 7) == 0)
			send_char(21'($urandom_range(0, 21'h1FFFFF)));
		else
			send_char(21'(finals[$urandom_range(0, finals.len() - 1)]));
	endtask

	// OSC title: number, separator, text, BEL; text occasionally overflows
	task automatic osc_seq();
		int len;
		logic [20:0] c;
		send_char(aesp_pkg::CH_ESC);
		send_char(aesp_pkg::CH_RBRK);
		if ($urandom_range(0, 4) != 0) send_num($urandom_range(0, 120));
		if ($urandom_range(0, 9) == 0) begin
			send_char(21'($urandom_range(64, 126)));   // ends early as a CSI final
			return;
		end
		send_char(aesp_pkg::CH_SEMI);
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
		for (int i = 0; i < len; i++) begin
			c = 21'($urandom_range(0, 21'h1FFFFF));
			if (c == aesp_pkg::CH_BEL) c = aesp_pkg::CH_SPACE;
			send_char(c);
		end
		send_char(aesp_pkg::CH_BEL);
	endtask

	// wait with input idle until every owed result has come
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (predictor.owed.size() != 0) @(negedge clk);
	endtask

	initial begin
		int r;
		predictor = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		chars_sent = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, every final, the odd corners
		send_char(aesp_pkg::CH_SPACE);
		send_char(21'd127);
		send_char(21'h1FFFFF);
		send_char(21'd0);
		send_char(21'd31);
		send_str("\033x");                    // unknown after ESC: dropped
		send_str("\033[A");
		send_str("\033[12345B");              // growth stops past 1000
		send_str("\033[9999D\033[C");
		send_str("\033[3;7H\033[f\033[2J\033[K");
		send_str("\033[1;4;7;31;42m\033[0m");
		send_str("\033[8;100;200t\033[9;5t\033[2t\033[3;5000;1t");
		send_str("\033[z");                    // unknown final
		send_str("\033[1;2;3;4;5;6;7;8;9;10;32m");   // too many parameters
		send_str("\033]2;hi\007\033]0;\007\033]3A");
		send_str("\033]5;");
		for (int i = 0; i < 66; i++) send_char(21'(65 + i % 26));   // text overflow
		send_char(aesp_pkg::CH_BEL);

		// sender pauses until everything has come back
		drain();

		// receiver holds off for a long stretch while the sender keeps going
		hold_request = 1;
		while (chars_sent < TOTAL_CHARS) begin
			r = $urandom_range(0, 99);
			if (r < 40) csi_seq();
			else if (r < 60) osc_seq();
			else if (r < 80) send_char(21'($urandom_range(0, 21'h1FFFFF)));
			else if (r < 90) send_char(21'($urandom_range(0, 31)));
			else begin
				send_char(aesp_pkg::CH_ESC);
				send_char(21'($urandom_range(0, 21'h1FFFFF)));
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (predictor.errors == 0 && predictor.owed.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
